// ===== design/tcw_pkg.sv =====
// Shared types, codes and constants of the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

	// Default screen geometry
	localparam int TCW_COLUMNS = 80;
	localparam int TCW_ROWS    = 25;

	// Character and attribute constants
	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] SPACE_CODE   = 8'h20;
	localparam logic [7:0] RESET_COLOR  = 8'h0F;

	// Request codes
	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_MOVE  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	// Register file: one register, index taken from paddr above the byte offset
	localparam int         TCW_PADDR_W    = 3;
	localparam logic [0:0] REG_TEXT_COLOR = 1'b0;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] char_code;
		logic [7:0] target_row;
		logic [7:0] target_col;
	} tcw_req_t;

	typedef struct packed {
		logic [4:0]  loc_row;
		logic [6:0]  loc_col;
		logic [10:0] cursor_pos;
		logic        scrolled;
		logic [15:0] cell_value;
	} tcw_rsp_t;

	// Cursor update selected by the controller
	typedef enum logic [1:0] {
		CUR_HOLD    = 2'd0,
		CUR_ADVANCE = 2'd1,
		CUR_MOVE    = 2'd2,
		CUR_HOME    = 2'd3
	} tcw_cur_op_t;

	// Controller to datapath
	typedef struct packed {
		logic        capture;
		tcw_cur_op_t cur_op;
		logic        put_write;
		logic        fill_wr;
		logic        fill_reset_color;
		logic        idx_clr;
		logic        idx_inc;
		logic        copy_step;
		logic        rd_issue;
		logic        out_load;
		logic        out_scrolled;
		logic        out_cell;
	} tcw_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic overflow;
		logic sweep_last;
		logic copy_last;
		logic out_free;
	} tcw_status_t;

endpackage

// ===== design/text_console_writer_unit.sv =====
// Top level of the text console writer: register port, controller and datapath.
//
// Requests arrive on req (req_valid/req_ready) and each one gives exactly one
// result on rsp (rsp_valid/rsp_ready): the cursor after the request, its linear
// position, a scroll flag and, for a read, the cell (attribute high, character low).
// One request is worked at a time. A put that runs past the last row scrolls:
// it copies ROWS*COLUMNS-COLUMNS cells and blanks one row over the single
// memory write port. A clear writes every cell. After reset the screen is
// filled with blanks in color 0x0F, one cell per cycle; req_ready stays low
// until then, while register writes are taken as ever.
// The result sits in an output register; a stalled receiver holds it and the
// block still accepts the next request, but does not finish it until the
// register is free. text_color is written over the APB port at address 0.
`timescale 1ns / 1ps

module text_console_writer_unit import tcw_pkg::*; #(
	parameter int COLUMNS = TCW_COLUMNS,
	parameter int ROWS    = TCW_ROWS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [TCW_PADDR_W-1:0] paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  tcw_req_t               req,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output tcw_rsp_t               rsp
);

	logic [7:0]  text_color_q;
	logic        reg_hit;
	tcw_cmd_t    cmd;
	tcw_status_t status;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[TCW_PADDR_W-1:2] == REG_TEXT_COLOR);

	// Write the color register on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= RESET_COLOR;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			text_color_q <= pwdata[7:0];
		end
	end

	assign prdata = reg_hit ? {24'h000000, text_color_q} : 32'h00000000;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	tcw_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.text_color (text_color_q),
		.cmd        (cmd),
		.status     (status),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule

// ===== design/tcw_ctrl.sv =====
// Controller state machine of the text console writer.
`timescale 1ns / 1ps

module tcw_ctrl import tcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic [1:0]  req_type,
	output logic        req_ready,
	input  tcw_status_t status,
	output tcw_cmd_t    cmd
);

	typedef enum logic [10:0] {
		S_INIT     = 11'b000_0000_0001,
		S_IDLE     = 11'b000_0000_0010,
		S_PUT      = 11'b000_0000_0100,
		S_MOVE     = 11'b000_0000_1000,
		S_RD_ADDR  = 11'b000_0001_0000,
		S_RD_DATA  = 11'b000_0010_0000,
		S_CLEAR    = 11'b000_0100_0000,
		S_COPY     = 11'b000_1000_0000,
		S_BLANK    = 11'b001_0000_0000,
		S_DONE_CLR = 11'b010_0000_0000,
		S_DONE_SCR = 11'b100_0000_0000
	} tcw_state_t;

	tcw_state_t state_q;
	tcw_state_t state_nxt;

	// Next state and datapath commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.cur_op = CUR_HOLD;
		req_ready = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.fill_wr          = 1'b1;
				cmd.fill_reset_color = 1'b1;
				cmd.idx_inc          = 1'b1;
				if (status.sweep_last) begin
					cmd.idx_clr = 1'b1;
					state_nxt   = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					case (req_type)
						REQ_PUT:   state_nxt = S_PUT;
						REQ_MOVE:  state_nxt = S_MOVE;
						REQ_CLEAR: state_nxt = S_CLEAR;
						default:   state_nxt = S_RD_ADDR;
					endcase
				end
			end
			S_PUT: begin
				if (status.out_free) begin
					cmd.put_write = 1'b1;
					cmd.cur_op    = CUR_ADVANCE;
					if (status.overflow) begin
						cmd.idx_clr = 1'b1;
						state_nxt   = S_COPY;
					end else begin
						cmd.out_load = 1'b1;
						state_nxt    = S_IDLE;
					end
				end
			end
			S_MOVE: begin
				if (status.out_free) begin
					cmd.cur_op   = CUR_MOVE;
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			S_RD_ADDR: begin
				cmd.rd_issue = 1'b1;
				state_nxt    = S_RD_DATA;
			end
			S_RD_DATA: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_cell = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			S_CLEAR: begin
				cmd.fill_wr = 1'b1;
				cmd.idx_inc = 1'b1;
				if (status.sweep_last) begin
					cmd.idx_clr = 1'b1;
					cmd.cur_op  = CUR_HOME;
					state_nxt   = S_DONE_CLR;
				end
			end
			S_COPY: begin
				cmd.copy_step = 1'b1;
				// hold the index on the last copy so the blank pass starts at the bottom row
				if (status.copy_last) begin
					state_nxt = S_BLANK;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_BLANK: begin
				cmd.fill_wr = 1'b1;
				cmd.idx_inc = 1'b1;
				if (status.sweep_last) begin
					cmd.idx_clr = 1'b1;
					state_nxt   = S_DONE_SCR;
				end
			end
			S_DONE_CLR: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			S_DONE_SCR: begin
				if (status.out_free) begin
					cmd.out_load     = 1'b1;
					cmd.out_scrolled = 1'b1;
					state_nxt        = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_INIT;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== design/tcw_dp.sv =====
// Datapath of the text console writer: screen memory, cursor, sweep index and result register.
`timescale 1ns / 1ps

module tcw_dp import tcw_pkg::*; #(
	parameter int COLUMNS = TCW_COLUMNS,
	parameter int ROWS    = TCW_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  tcw_req_t    req,
	input  logic [7:0]  text_color,
	input  tcw_cmd_t    cmd,
	output tcw_status_t status,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output tcw_rsp_t    rsp
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int AW    = $clog2(CELLS);

	localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
	localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
	localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);
	localparam logic [8:0]    ROWS_9    = 9'(ROWS);
	localparam logic [8:0]    COLS_9    = 9'(COLUMNS);

	tcw_req_t      item_q;
	logic [RW-1:0] cur_row_q;
	logic [CW-1:0] cur_col_q;
	logic [AW-1:0] idx_q;
	logic [15:0]   rdata_q;
	tcw_rsp_t      rsp_q;
	logic          rsp_valid_q;
	logic [15:0]   mem [CELLS];

	logic [RW-1:0] trow;
	logic [CW-1:0] tcol;
	logic          is_newline;
	logic          row_adv;
	logic          overflow;
	logic [RW-1:0] adv_row;
	logic [CW-1:0] adv_col;
	logic [RW-1:0] next_row;
	logic [CW-1:0] next_col;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] next_addr;
	logic [AW-1:0] tgt_addr;
	logic [7:0]    fill_color;
	logic          we;
	logic [AW-1:0] waddr;
	logic [15:0]   wdata;
	logic          re;
	logic [AW-1:0] raddr;

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
	                                             input logic [CW-1:0] c);
		cell_addr = AW'(AW'(r) * COLS_A) + AW'(c);
	endfunction

	// Clamp the requested row and column
	assign trow = ({1'b0, item_q.target_row} >= ROWS_9) ? LAST_ROW : RW'(item_q.target_row);
	assign tcol = ({1'b0, item_q.target_col} >= COLS_9) ? LAST_COL : CW'(item_q.target_col);

	// Advance after a put; past the last row the cursor parks at the bottom row start
	assign is_newline = (item_q.char_code == NEWLINE_CODE);
	assign row_adv    = is_newline || (cur_col_q == LAST_COL);
	assign overflow   = row_adv && (cur_row_q == LAST_ROW);
	assign adv_row    = overflow ? LAST_ROW : (row_adv ? cur_row_q + RW'(1) : cur_row_q);
	assign adv_col    = row_adv ? '0 : cur_col_q + CW'(1);

	// Select the cursor after this cycle
	always_comb begin
		case (cmd.cur_op)
			CUR_ADVANCE: begin
				next_row = adv_row;
				next_col = adv_col;
			end
			CUR_MOVE: begin
				next_row = trow;
				next_col = tcol;
			end
			CUR_HOME: begin
				next_row = '0;
				next_col = '0;
			end
			default: begin
				next_row = cur_row_q;
				next_col = cur_col_q;
			end
		endcase
	end

	assign cur_addr  = cell_addr(cur_row_q, cur_col_q);
	assign next_addr = cell_addr(next_row, next_col);
	assign tgt_addr  = cell_addr(trow, tcol);

	assign fill_color = cmd.fill_reset_color ? RESET_COLOR : text_color;

	// Write port: character store, blank fill or scroll copy
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = {fill_color, SPACE_CODE};
		if (cmd.put_write && !is_newline) begin
			we    = 1'b1;
			waddr = cur_addr;
			wdata = {text_color, item_q.char_code};
		end else if (cmd.fill_wr) begin
			we = 1'b1;
		end else if (cmd.copy_step && (idx_q != '0)) begin
			we    = 1'b1;
			waddr = idx_q - AW'(1);
			wdata = rdata_q;
		end
	end

	// Read port: cell read or the source row of a scroll copy
	always_comb begin
		re    = cmd.rd_issue;
		raddr = tgt_addr;
		if (cmd.copy_step && (idx_q != COPY_END)) begin
			re    = 1'b1;
			raddr = idx_q + COLS_A;
		end
	end

	// Screen memory with registered read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// Capture the request and load the result
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req;
		end
		if (cmd.out_load) begin
			rsp_q.loc_row    <= 5'(next_row);
			rsp_q.loc_col    <= 7'(next_col);
			rsp_q.cursor_pos <= 11'(next_addr);
			rsp_q.scrolled   <= cmd.out_scrolled;
			rsp_q.cell_value <= cmd.out_cell ? rdata_q : 16'h0000;
		end
	end

	// Cursor, sweep index and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			cur_row_q <= next_row;
			cur_col_q <= next_col;
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + AW'(1);
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign status.overflow   = overflow;
	assign status.sweep_last = (idx_q == LAST_CELL);
	assign status.copy_last  = (idx_q == COPY_END);
	assign status.out_free   = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
